// ===== design/indirect_block_map_walker_unit_macros.svh =====
// Assertion macros for the indirect block map walker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef INDIRECT_BLOCK_MAP_WALKER_UNIT_MACROS_SVH
`define INDIRECT_BLOCK_MAP_WALKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IBMW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IBMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ibmw_pkg.sv =====
// Shared constants, codes, request structs and helpers of the block map walker.
// No dependencies; the header map, the sequencer and the top level refer to it by scoped names.
`default_nettype none

package ibmw_pkg;

  localparam int unsigned MAP_ENTRIES     = 64;
  localparam int unsigned WORDS_PER_BLOCK = 128;
  localparam int unsigned CACHED_LEVELS   = 3;
  localparam int unsigned LEVEL_BITS      = 7;
  localparam logic [31:0] INDEX_MASK      = 32'd127;
  localparam int unsigned MAX_WALK_LEVEL  = 4;

  localparam int unsigned HDR_AW      = $clog2(MAP_ENTRIES);
  localparam int unsigned CACHE_DEPTH = CACHED_LEVELS * WORDS_PER_BLOCK;
  localparam int unsigned CACHE_AW    = $clog2(CACHE_DEPTH);
  localparam int unsigned WORD_AW     = $clog2(WORDS_PER_BLOCK);
  localparam int unsigned SLOT_W      = (CACHED_LEVELS > 1) ? $clog2(CACHED_LEVELS) : 1;
  localparam int unsigned LVL_W       = $clog2(MAX_WALK_LEVEL + 1);
  localparam int unsigned CFG_IW      = 8;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_DIRECT_COUNT    = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_INDIRECT_LEVELS = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_XLATE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_FAIL  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_RANGE = 3'd2,
    KIND_FAIL  = 3'd3,
    KIND_BUSY  = 3'd4
  } kind_e;

  typedef struct packed {
    logic              we;
    logic [HDR_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [HDR_AW-1:0] raddr;
  } hdr_req_t;

  typedef struct packed {
    logic                we;
    logic [CACHE_AW-1:0] waddr;
    logic [31:0]         wdata;
    logic                re;
    logic [CACHE_AW-1:0] raddr;
  } cache_req_t;

  // Map indirect level 1..3 to its cache slot, (lvl - 1) mod CACHED_LEVELS
  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] lvl);
    logic [1:0] v;
    v = lvl - 2'd1;
    for (int i = 0; i < 2; i++) begin
      if (32'(v) >= CACHED_LEVELS) begin
        v = v - 2'(CACHED_LEVELS);
      end
    end
    return SLOT_W'(v);
  endfunction

  // Word address of one entry in the level cache memory
  function automatic logic [CACHE_AW-1:0] cache_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [WORD_AW-1:0] word);
    return CACHE_AW'(slot) * CACHE_AW'(WORDS_PER_BLOCK) + CACHE_AW'(word);
  endfunction

endpackage

`default_nettype wire

// ===== design/ibmw_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Holds the level cache data; no dependencies.
`default_nettype none

module ibmw_ram #(
  parameter int unsigned DEPTH = 384,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ibmw_hdr_map.sv =====
// Header map memory with one valid bit per entry so reset reads back zero.
// Depends on ibmw_pkg for the depth and the request struct.
`default_nettype none

module ibmw_hdr_map (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ibmw_pkg::hdr_req_t req_i,
  output logic [31:0]            rdata_o
);

  logic [31:0]                        mem_q [ibmw_pkg::MAP_ENTRIES];
  logic [ibmw_pkg::MAP_ENTRIES-1:0]   vld_q;
  logic [31:0]                        rd_data_q;
  logic                               rd_vld_q;

  // Write and read the entry array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  // Track written entries; reset clears them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = rd_vld_q ? rd_data_q : 32'd0;

endmodule

`default_nettype wire

// ===== design/ibmw_ctrl.sv =====
// Walk sequencer: decodes commands, walks cached levels, owns tags and output register.
// Depends on ibmw_pkg and the assertion macro header.
`default_nettype none
`include "indirect_block_map_walker_unit_macros.svh"

module ibmw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [ibmw_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [5:0]           map_index_i,
  input  wire logic [31:0]          value_i,
  input  wire logic [31:0]          logical_block_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                kind_o,
  output logic [31:0]               block_o,
  output logic [1:0]                cache_level_o,
  output ibmw_pkg::hdr_req_t        hdr_req_o,
  input  wire logic [31:0]          hdr_rdata_i,
  output ibmw_pkg::cache_req_t      cache_req_o,
  input  wire logic [31:0]          cache_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_STEP,
    ST_RD,
    ST_EMIT
  } state_e;

  localparam int unsigned CL = ibmw_pkg::CACHED_LEVELS;

  state_e state_q, state_d;

  logic [6:0]  dc_q, dc_d;
  logic [1:0]  lv_q, lv_d;

  logic [31:0] tag_q [CL];
  logic [31:0] tag_d [CL];
  logic [CL-1:0] cvld_q, cvld_d;

  logic                        pending_q, pending_d;
  logic [ibmw_pkg::WORD_AW-1:0] fill_cnt_q, fill_cnt_d;
  logic [1:0]                  walk_level_q, walk_level_d;
  logic [31:0]                 walk_logical_q, walk_logical_d;
  logic [31:0]                 walk_ptr_q, walk_ptr_d;

  logic [31:0]                 logical_q, logical_d;
  logic                        direct_q, direct_d;
  logic [31:0]                 bn_q, bn_d;
  logic [ibmw_pkg::LVL_W-1:0]  lvl_q, lvl_d;

  ibmw_pkg::kind_e             res_kind_q, res_kind_d;
  logic [31:0]                 res_block_q, res_block_d;
  logic [1:0]                  res_level_q, res_level_d;

  logic                        out_valid_q, out_valid_d;
  ibmw_pkg::kind_e             out_kind_q, out_kind_d;
  logic [31:0]                 out_block_q, out_block_d;
  logic [1:0]                  out_level_q, out_level_d;

  // Translate decode on the incoming item
  logic [4:0]  hdr_shift;
  logic [31:0] hdr_shifted;
  logic [32:0] hdr_idx;
  logic        is_direct;
  logic        direct_oob;
  logic        indirect_oob;
  logic        load_ok;

  // Walk step decode
  logic [ibmw_pkg::SLOT_W-1:0]  step_slot;
  logic [ibmw_pkg::SLOT_W-1:0]  walk_slot;
  logic [1:0]                   step_diff;
  logic [4:0]                   step_shift;
  logic [ibmw_pkg::WORD_AW-1:0] step_word;
  logic                         step_hit;
  logic                         step_end;

  assign hdr_shift    = 5'(lv_q) * 5'(ibmw_pkg::LEVEL_BITS);
  assign hdr_shifted  = logical_block_i >> hdr_shift;
  assign hdr_idx      = 33'(dc_q) + 33'(hdr_shifted);
  assign is_direct    = logical_block_i < 32'(dc_q);
  assign direct_oob   = logical_block_i >= 32'(ibmw_pkg::MAP_ENTRIES);
  assign indirect_oob = hdr_idx >= 33'(ibmw_pkg::MAP_ENTRIES);
  assign load_ok      = 32'(map_index_i) < 32'(ibmw_pkg::MAP_ENTRIES);

  assign step_end   = (bn_q == 32'd0) || (lvl_q > ibmw_pkg::LVL_W'(lv_q));
  assign step_slot  = ibmw_pkg::slot_of(lvl_q[1:0]);
  assign walk_slot  = ibmw_pkg::slot_of(walk_level_q);
  assign step_diff  = lv_q - lvl_q[1:0];
  assign step_shift = 5'(step_diff) * 5'(ibmw_pkg::LEVEL_BITS);
  assign step_word  = ibmw_pkg::WORD_AW'((logical_q >> step_shift) & ibmw_pkg::INDEX_MASK);
  assign step_hit   = cvld_q[step_slot] && (tag_q[step_slot] == bn_q);

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign block_o       = out_block_q;
  assign cache_level_o = out_level_q;

  // Next-state logic
  always_comb begin
    state_d        = state_q;
    dc_d           = dc_q;
    lv_d           = lv_q;
    tag_d          = tag_q;
    cvld_d         = cvld_q;
    pending_d      = pending_q;
    fill_cnt_d     = fill_cnt_q;
    walk_level_d   = walk_level_q;
    walk_logical_d = walk_logical_q;
    walk_ptr_d     = walk_ptr_q;
    logical_d      = logical_q;
    direct_d       = direct_q;
    bn_d           = bn_q;
    lvl_d          = lvl_q;
    res_kind_d     = res_kind_q;
    res_block_d    = res_block_q;
    res_level_d    = res_level_q;
    out_valid_d    = out_valid_q;
    out_kind_d     = out_kind_q;
    out_block_d    = out_block_q;
    out_level_d    = out_level_q;
    hdr_req_o      = '0;
    cache_req_o    = '0;

    // Take configuration writes; unknown indexes are dropped
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ibmw_pkg::CFG_DIRECT_COUNT:    dc_d = cfg_data_i[6:0];
        ibmw_pkg::CFG_INDIRECT_LEVELS: lv_d = cfg_data_i[1:0];
        default: ;
      endcase
    end

    // Drain the output register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (ibmw_pkg::cmd_e'(command_i))
            ibmw_pkg::CMD_LOAD: begin
              if (load_ok) begin
                hdr_req_o.we    = 1'b1;
                hdr_req_o.waddr = ibmw_pkg::HDR_AW'(map_index_i);
                hdr_req_o.wdata = value_i;
              end
            end
            ibmw_pkg::CMD_XLATE: begin
              if (pending_q) begin
                res_kind_d  = ibmw_pkg::KIND_BUSY;
                res_block_d = 32'd0;
                res_level_d = 2'd0;
                state_d     = ST_EMIT;
              end else if (is_direct ? direct_oob : indirect_oob) begin
                res_kind_d  = ibmw_pkg::KIND_RANGE;
                res_block_d = 32'd0;
                res_level_d = 2'd0;
                state_d     = ST_EMIT;
              end else begin
                logical_d       = logical_block_i;
                direct_d        = is_direct;
                hdr_req_o.re    = 1'b1;
                hdr_req_o.raddr = is_direct ? ibmw_pkg::HDR_AW'(logical_block_i)
                                            : ibmw_pkg::HDR_AW'(hdr_idx);
                state_d         = ST_HDR;
              end
            end
            ibmw_pkg::CMD_FILL: begin
              if (pending_q) begin
                cache_req_o.we    = 1'b1;
                cache_req_o.waddr = ibmw_pkg::cache_addr(walk_slot, fill_cnt_q);
                cache_req_o.wdata = value_i;
                if (fill_cnt_q == ibmw_pkg::WORD_AW'(ibmw_pkg::WORDS_PER_BLOCK - 1)) begin
                  // Last word: mark the block cached and resume the walk
                  fill_cnt_d        = '0;
                  tag_d[walk_slot]  = walk_ptr_q;
                  cvld_d[walk_slot] = 1'b1;
                  pending_d         = 1'b0;
                  logical_d         = walk_logical_q;
                  bn_d              = walk_ptr_q;
                  lvl_d             = ibmw_pkg::LVL_W'(walk_level_q);
                  state_d           = ST_STEP;
                end else begin
                  fill_cnt_d = fill_cnt_q + 1'b1;
                end
              end
            end
            ibmw_pkg::CMD_FAIL: begin
              if (pending_q) begin
                pending_d         = 1'b0;
                fill_cnt_d        = '0;
                cvld_d[walk_slot] = 1'b0;
                res_kind_d        = ibmw_pkg::KIND_FAIL;
                res_block_d       = walk_ptr_q;
                res_level_d       = walk_level_q;
                state_d           = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_HDR: begin
        if (direct_q) begin
          res_kind_d  = ibmw_pkg::KIND_DONE;
          res_block_d = hdr_rdata_i;
          res_level_d = 2'd0;
          state_d     = ST_EMIT;
        end else begin
          bn_d    = hdr_rdata_i;
          lvl_d   = ibmw_pkg::LVL_W'(1);
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (step_end) begin
          // Hole or bottom reached
          res_kind_d  = ibmw_pkg::KIND_DONE;
          res_block_d = bn_q;
          res_level_d = 2'd0;
          state_d     = ST_EMIT;
        end else if (step_hit) begin
          cache_req_o.re    = 1'b1;
          cache_req_o.raddr = ibmw_pkg::cache_addr(step_slot, step_word);
          state_d           = ST_RD;
        end else begin
          // Miss: save the walk and request the pointer block
          cvld_d[step_slot] = 1'b0;
          pending_d         = 1'b1;
          fill_cnt_d        = '0;
          walk_level_d      = lvl_q[1:0];
          walk_logical_d    = logical_q;
          walk_ptr_d        = bn_q;
          res_kind_d        = ibmw_pkg::KIND_READ;
          res_block_d       = bn_q;
          res_level_d       = lvl_q[1:0];
          state_d           = ST_EMIT;
        end
      end

      ST_RD: begin
        bn_d    = cache_rdata_i;
        lvl_d   = lvl_q + 1'b1;
        state_d = ST_STEP;
      end

      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_block_d = res_block_q;
          out_level_d = res_level_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      dc_q           <= 7'd0;
      lv_q           <= 2'd1;
      tag_q          <= '{default: 32'd0};
      cvld_q         <= '0;
      pending_q      <= 1'b0;
      fill_cnt_q     <= '0;
      walk_level_q   <= 2'd0;
      walk_logical_q <= 32'd0;
      walk_ptr_q     <= 32'd0;
      logical_q      <= 32'd0;
      direct_q       <= 1'b0;
      bn_q           <= 32'd0;
      lvl_q          <= '0;
      res_kind_q     <= ibmw_pkg::KIND_DONE;
      res_block_q    <= 32'd0;
      res_level_q    <= 2'd0;
      out_valid_q    <= 1'b0;
      out_kind_q     <= ibmw_pkg::KIND_DONE;
      out_block_q    <= 32'd0;
      out_level_q    <= 2'd0;
    end else begin
      state_q        <= state_d;
      dc_q           <= dc_d;
      lv_q           <= lv_d;
      tag_q          <= tag_d;
      cvld_q         <= cvld_d;
      pending_q      <= pending_d;
      fill_cnt_q     <= fill_cnt_d;
      walk_level_q   <= walk_level_d;
      walk_logical_q <= walk_logical_d;
      walk_ptr_q     <= walk_ptr_d;
      logical_q      <= logical_d;
      direct_q       <= direct_d;
      bn_q           <= bn_d;
      lvl_q          <= lvl_d;
      res_kind_q     <= res_kind_d;
      res_block_q    <= res_block_d;
      res_level_q    <= res_level_d;
      out_valid_q    <= out_valid_d;
      out_kind_q     <= out_kind_d;
      out_block_q    <= out_block_d;
      out_level_q    <= out_level_d;
    end
  end

  // A pending read always refers to a real pointer block
  `IBMW_ASSERT_IMPL(a_pending_ptr, pending_q, walk_ptr_q != 32'd0, "pending read of block zero")
  `IBMW_ASSERT_IMPL(a_pending_level, pending_q, walk_level_q != 2'd0, "pending read at level zero")
  // Cache reads only for a live pointer within the configured depth
  `IBMW_ASSERT_IMPL(a_rd_in_walk, state_q == ST_RD,
                    (bn_q != 32'd0) && (lvl_q <= ibmw_pkg::LVL_W'(lv_q)),
                    "cache read outside the walk")
  // A new pending read is reported as a read request
  `IBMW_ASSERT_IMPL(a_miss_report, $rose(pending_q),
                    (state_q == ST_EMIT) && (res_kind_q == ibmw_pkg::KIND_READ),
                    "miss without read request")
  // Translate during a pending read answers busy
  `IBMW_ASSERT_NEXT(a_busy_answer,
                    in_valid_i && in_ready_o && pending_q &&
                    (command_i == ibmw_pkg::CMD_XLATE),
                    (state_q == ST_EMIT) && (res_kind_q == ibmw_pkg::KIND_BUSY),
                    "translate while pending not answered busy")

endmodule

`default_nettype wire

// ===== design/indirect_block_map_walker_unit.sv =====
// Channel    Handshake                 Payload
// cfg        cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in         in_valid_i/in_ready_o     command_i, map_index_i, value_i, logical_block_i
// out        out_valid_o/out_ready_i   kind_o, block_o, cache_level_o
//
// Load and fill items are taken while idle; busy, range and read-failed answers go to the
// output register. A translation reads the header map; an indirect one then does a tag check
// and cache RAM read per cached level read, a last tag check and the output register. A last
// fill word resumes the walk at the tag check. Reset clears the header map through per-entry
// valid bits. One output register parts the sides; the walker waits there while the result
// is not taken, and takes a new item only when idle. Configuration is always ready.
//
// Top level: instantiates the header map, the level cache RAM and the walk sequencer.
// Depends on ibmw_pkg, ibmw_ram, ibmw_hdr_map and ibmw_ctrl.
`default_nettype none

module indirect_block_map_walker_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ibmw_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [5:0]                  map_index_i,
  input  wire logic [31:0]                 value_i,
  input  wire logic [31:0]                 logical_block_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       kind_o,
  output logic [31:0]                      block_o,
  output logic [1:0]                       cache_level_o
);

  ibmw_pkg::hdr_req_t   hdr_req;
  ibmw_pkg::cache_req_t cache_req;
  logic [31:0]          hdr_rdata;
  logic [31:0]          cache_rdata;

  // Header map with reset-to-zero entries
  ibmw_hdr_map u_hdr_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (hdr_req),
    .rdata_o (hdr_rdata)
  );

  // Level cache data, one block per cached level
  ibmw_ram #(
    .DEPTH (ibmw_pkg::CACHE_DEPTH),
    .WIDTH (32)
  ) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cache_req.we),
    .waddr_i (cache_req.waddr),
    .wdata_i (cache_req.wdata),
    .re_i    (cache_req.re),
    .raddr_i (cache_req.raddr),
    .rdata_o (cache_rdata)
  );

  // Walk sequencer
  ibmw_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .map_index_i     (map_index_i),
    .value_i         (value_i),
    .logical_block_i (logical_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .block_o         (block_o),
    .cache_level_o   (cache_level_o),
    .hdr_req_o       (hdr_req),
    .hdr_rdata_i     (hdr_rdata),
    .cache_req_o     (cache_req),
    .cache_rdata_i   (cache_rdata)
  );

endmodule

`default_nettype wire
